// File: rtl/cet_pkg.sv
// Shared types, constants and the control store for the crystal error
// correction tracker. No dependencies; used by every module in rtl/.
package cet_pkg;

	// Block constants
	localparam int INIT_COUNT   = 128;
	localparam int FILTER_COEF  = 256;     // must be a power of two
	localparam int FILTER_SHIFT = $clog2(FILTER_COEF);

	localparam int SUM_W       = 39;
	localparam int QUO_W       = 32;
	localparam int DIV_STEPS   = 32;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
	localparam int APB_AW      = 3;

	localparam logic [31:0]      ONE_Q30       = 32'h4000_0000;
	localparam logic [15:0]      MAX_AGE_RESET = 16'd30;
	localparam logic [SUM_W-1:0] SUM_MAX       = '1;
	localparam logic [7:0]       COUNT_FULL    = 8'(INIT_COUNT);

	// Partial remainder loaded into the divider: numerator * 2^28
	localparam logic [SUM_W-1:0] EST_NUM = SUM_W'(INIT_COUNT) << 28;
	localparam logic [SUM_W-1:0] TRK_NUM = SUM_W'(1) << 28;

	// Register index, taken from paddr[APB_AW-1]
	localparam logic REG_MAX_AGE = 1'b0;

	// Channel words
	typedef struct packed {
		logic signed [31:0] ref_age;
		logic [31:0]        error_ratio;
	} in_word_t;

	typedef struct packed {
		logic        ref_valid;
		logic        correction_ok;
		logic [31:0] correction;
	} out_word_t;

	// Divider control from the sequencer
	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

	// Microcode
	typedef enum logic [3:0] {
		UOP_NOP       = 4'd0,
		UOP_LATCH     = 4'd1,
		UOP_CLEAR     = 4'd2,
		UOP_ACCUM     = 4'd3,
		UOP_LOAD_EST  = 4'd4,
		UOP_LOAD_TRK  = 4'd5,
		UOP_DIV_STEP  = 4'd6,
		UOP_EST_WRITE = 4'd7,
		UOP_TRK_WRITE = 4'd8,
		UOP_EMIT      = 4'd9
	} uop_t;

	typedef enum logic [2:0] {
		COND_NEVER       = 3'd0,
		COND_ALWAYS      = 3'd1,
		COND_NO_ITEM     = 3'd2,
		COND_REF_BAD     = 3'd3,
		COND_CORR_VALID  = 3'd4,
		COND_COUNT_FULL  = 3'd5,
		COND_DIV_MORE    = 3'd6,
		COND_OUT_BLOCKED = 3'd7
	} ucond_t;

	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_IDLE     = 4'd0;
	localparam step_t STEP_CHK_REF  = 4'd1;
	localparam step_t STEP_CHK_VAL  = 4'd2;
	localparam step_t STEP_CHK_CNT  = 4'd3;
	localparam step_t STEP_ACCUM    = 4'd4;
	localparam step_t STEP_CLEAR    = 4'd5;
	localparam step_t STEP_EST_LOAD = 4'd6;
	localparam step_t STEP_EST_DIV  = 4'd7;
	localparam step_t STEP_EST_WR   = 4'd8;
	localparam step_t STEP_TRK_LOAD = 4'd9;
	localparam step_t STEP_TRK_DIV  = 4'd10;
	localparam step_t STEP_TRK_WR   = 4'd11;
	localparam step_t STEP_EMIT     = 4'd12;
	localparam step_t STEP_RETURN   = 4'd13;

	// If cond holds, jump to target; else fall through to the next step
	typedef struct packed {
		uop_t   op;
		ucond_t cond;
		step_t  target;
	} ucode_t;

	function automatic ucode_t ucode_rom(step_t s);
		ucode_t w;
		case (s)
			STEP_IDLE:     w = ucode_t'{UOP_LATCH,     COND_NO_ITEM,     STEP_IDLE};
			STEP_CHK_REF:  w = ucode_t'{UOP_NOP,       COND_REF_BAD,     STEP_CLEAR};
			STEP_CHK_VAL:  w = ucode_t'{UOP_NOP,       COND_CORR_VALID,  STEP_TRK_LOAD};
			STEP_CHK_CNT:  w = ucode_t'{UOP_NOP,       COND_COUNT_FULL,  STEP_EST_LOAD};
			STEP_ACCUM:    w = ucode_t'{UOP_ACCUM,     COND_ALWAYS,      STEP_EMIT};
			STEP_CLEAR:    w = ucode_t'{UOP_CLEAR,     COND_ALWAYS,      STEP_EMIT};
			STEP_EST_LOAD: w = ucode_t'{UOP_LOAD_EST,  COND_NEVER,       STEP_IDLE};
			STEP_EST_DIV:  w = ucode_t'{UOP_DIV_STEP,  COND_DIV_MORE,    STEP_EST_DIV};
			STEP_EST_WR:   w = ucode_t'{UOP_EST_WRITE, COND_ALWAYS,      STEP_EMIT};
			STEP_TRK_LOAD: w = ucode_t'{UOP_LOAD_TRK,  COND_NEVER,       STEP_IDLE};
			STEP_TRK_DIV:  w = ucode_t'{UOP_DIV_STEP,  COND_DIV_MORE,    STEP_TRK_DIV};
			STEP_TRK_WR:   w = ucode_t'{UOP_TRK_WRITE, COND_NEVER,       STEP_IDLE};
			STEP_EMIT:     w = ucode_t'{UOP_EMIT,      COND_OUT_BLOCKED, STEP_EMIT};
			STEP_RETURN:   w = ucode_t'{UOP_NOP,       COND_ALWAYS,      STEP_IDLE};
			default:       w = ucode_t'{UOP_NOP,       COND_ALWAYS,      STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/cet_divider.sv
// Restoring divider, one quotient bit per step, saturating to all ones.
// Depends on cet_pkg.
module cet_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cet_pkg::div_ctrl_t         ctrl,
	input  logic [cet_pkg::SUM_W-1:0]  num,
	input  logic [cet_pkg::SUM_W-1:0]  den,
	output logic [cet_pkg::QUO_W-1:0]  quo,
	output logic                       more
);
	import cet_pkg::*;

	logic [SUM_W-1:0]     rem_q;
	logic [SUM_W-1:0]     den_q;
	logic [QUO_W-1:0]     quo_q;
	logic                 sat_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic [SUM_W:0] shifted;
	logic [SUM_W:0] diff;
	logic           ge;

	// Trial subtract of the shifted remainder
	assign shifted = {rem_q, 1'b0};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.load) begin
			cnt_q <= DIV_CNT_W'(DIV_STEPS - 1);
		end else if (ctrl.step) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end
	end

	// Remainder and quotient; the quotient is known to fit unless sat
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
			sat_q <= (den <= num);
		end else if (ctrl.step) begin
			rem_q <= ge ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign more = (cnt_q != '0);
	assign quo  = sat_q ? '1 : quo_q;

endmodule

// File: rtl/crystal_error_correction_tracker.sv
// Top level of the crystal error correction tracker: microcoded sequencer,
// state registers, APB register and output register. Depends on cet_pkg,
// cet_divider.
//
// Usage:
//   One input word per tick on in_valid/in_stall (reference age and
//   measured error ratio); one result word per input on out_valid/out_stall
//   (reference valid flag, correction established flag, Q2.30 correction).
//   max_age is written over the APB port at offset 0; the user must write
//   it only while the block idles, and the block leaves this to the user. A
//   word is taken only when the sequencer sits at its idle step, so one
//   word is in work at a time. The two divide paths use the shared divider,
//   32 steps of one quotient bit each.
//   A stall on the output holds that register; a later word that reaches
//   its emit step waits there, keeping in_stall high, until the held
//   result moves on. A waiting result does not stop the next word from
//   being taken.
//   Reset: max_age = 30, correction = 1.0, not established, average empty,
//   output register empty.
module crystal_error_correction_tracker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  cet_pkg::in_word_t            in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output cet_pkg::out_word_t           out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cet_pkg::APB_AW-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import cet_pkg::*;

	// Sequencer
	step_t  pc_q;
	ucode_t uw;
	logic   taken;

	// State
	logic [15:0]      max_age_q;
	logic             ref_ok_q;
	logic [31:0]      err_q;
	logic [7:0]       count_q;
	logic [SUM_W-1:0] sum_q;
	logic [31:0]      corr_q;
	logic             corr_valid_q;
	logic             out_valid_q;
	out_word_t        out_data_q;

	// Datapath signals
	logic             accept;
	logic             ref_ok;
	logic             out_blocked;
	logic             emit_go;
	logic [SUM_W:0]   sum_wide;
	logic [SUM_W-1:0] sum_next;
	logic [32:0]      filt_wide;
	logic [31:0]      filt;
	div_ctrl_t        div_ctrl;
	logic [SUM_W-1:0] div_num;
	logic [SUM_W-1:0] div_den;
	logic [QUO_W-1:0] div_quo;
	logic             div_more;
	logic             cfg_wr;

	assign uw = ucode_rom(pc_q);

	// Input handshake: open only at the idle step
	assign in_stall = (uw.op != UOP_LATCH);
	assign accept   = in_valid && !in_stall;

	assign out_blocked = out_valid_q && out_stall;
	assign emit_go     = (uw.op == UOP_EMIT) && !out_blocked;

	// Branch condition
	always_comb begin
		case (uw.cond)
			COND_NEVER:       taken = 1'b0;
			COND_ALWAYS:      taken = 1'b1;
			COND_NO_ITEM:     taken = !in_valid;
			COND_REF_BAD:     taken = !ref_ok_q;
			COND_CORR_VALID:  taken = corr_valid_q;
			COND_COUNT_FULL:  taken = (count_q >= COUNT_FULL);
			COND_DIV_MORE:    taken = div_more;
			COND_OUT_BLOCKED: taken = out_blocked;
			default:          taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= taken ? uw.target : pc_q + step_t'(1);
		end
	end

	// Reference age check: non-negative and within max_age
	assign ref_ok = (in_data.ref_age[31:16] == '0) && (in_data.ref_age[15:0] <= max_age_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			ref_ok_q <= ref_ok;
			err_q    <= in_data.error_ratio;
		end
	end

	// Saturating running sum
	assign sum_wide = {1'b0, sum_q} + (SUM_W + 1)'(err_q);
	assign sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

	// First order filter toward the reciprocal, clamped to 32 bits
	assign filt_wide = {1'b0, corr_q} - 33'(corr_q >> FILTER_SHIFT)
		+ 33'(div_quo >> FILTER_SHIFT);
	assign filt = filt_wide[32] ? '1 : filt_wide[31:0];

	// Shared divider
	assign div_ctrl.load = (uw.op == UOP_LOAD_EST) || (uw.op == UOP_LOAD_TRK);
	assign div_ctrl.step = (uw.op == UOP_DIV_STEP);
	assign div_num = (uw.op == UOP_LOAD_EST) ? EST_NUM : TRK_NUM;
	assign div_den = (uw.op == UOP_LOAD_EST) ? sum_q : SUM_W'(err_q);

	cet_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (div_ctrl),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.more   (div_more)
	);

	// Tracker state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			sum_q        <= '0;
			corr_q       <= ONE_Q30;
			corr_valid_q <= 1'b0;
		end else begin
			case (uw.op)
				UOP_CLEAR: begin
					count_q      <= '0;
					sum_q        <= '0;
					corr_q       <= ONE_Q30;
					corr_valid_q <= 1'b0;
				end
				UOP_ACCUM: begin
					count_q <= count_q + 8'd1;
					sum_q   <= sum_next;
				end
				UOP_EST_WRITE: begin
					corr_q       <= div_quo;
					corr_valid_q <= 1'b1;
				end
				UOP_TRK_WRITE: begin
					corr_q <= filt;
				end
				default: begin
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_data_q.ref_valid     <= ref_ok_q;
			out_data_q.correction_ok <= corr_valid_q;
			out_data_q.correction    <= corr_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// APB register
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[APB_AW-1] == REG_MAX_AGE) ? {16'b0, max_age_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= MAX_AGE_RESET;
		end else if (cfg_wr && (paddr[APB_AW-1] == REG_MAX_AGE)) begin
			max_age_q <= pwdata[15:0];
		end
	end

	// Checks
	a_ok_needs_ref: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.correction_ok |-> out_data.ref_valid)
		else $error("established correction reported with stale reference");

	a_bad_ref_resets: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.ref_valid |->
			(out_data.correction == ONE_Q30) && !out_data.correction_ok)
		else $error("stale reference did not reset the correction");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		corr_valid_q |-> (count_q == COUNT_FULL))
		else $error("correction established before the average filled");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (pc_q == STEP_CHK_REF))
		else $error("sequencer did not start the program after a word");

endmodule
